// ===== design/ftws_pkg.sv =====
package ftws_pkg;

    // Field widths
    localparam int unsigned TimeW   = 20;
    localparam int unsigned HeldW   = 9;
    localparam int unsigned CodeW   = 2;
    localparam int unsigned FracW   = 17;
    localparam int unsigned CfgIdxW = 2;

    // Fixed-point constants
    localparam logic [TimeW-1:0] BudgetFloorUs = TimeW'(1000);
    localparam logic [15:0]      Q16Half       = 16'h8000;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_FRAME_BUDGET = 2'd0,
        CFG_PCT_FRAC     = 2'd1,
        CFG_SHARE_LIMIT  = 2'd2
    } t_cfg_idx;

    // Operation codes
    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    // Load colour codes
    typedef enum logic [CodeW-1:0] {
        COLOUR_OK   = 2'd0,
        COLOUR_WARN = 2'd1,
        COLOUR_OVER = 2'd2
    } t_colour;

    // Triage verdict codes
    typedef enum logic [CodeW-1:0] {
        VERDICT_OK    = 2'd0,
        VERDICT_SIM   = 2'd1,
        VERDICT_OTHER = 2'd2,
        VERDICT_EMPTY = 2'd3
    } t_verdict;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_SUM,
        S_DIV,
        S_WAITDIV,
        S_RANK,
        S_CAND,
        S_CAND_WAIT,
        S_SCAN,
        S_JUDGE,
        S_PROD,
        S_FINISH
    } t_state;

endpackage

// ===== design/ftws_if.sv =====
// Input item channel
interface ftws_in_if;
    import ftws_pkg::*;
    logic             valid;
    logic             ready;
    logic             operation;
    logic [TimeW-1:0] frame_time_us;
    logic [TimeW-1:0] sim_cost_us;
    modport source (output valid, operation, frame_time_us, sim_cost_us, input ready);
    modport sink   (input valid, operation, frame_time_us, sim_cost_us, output ready);
endinterface

// Result item channel
interface ftws_out_if;
    import ftws_pkg::*;
    logic             valid;
    logic             ready;
    logic [TimeW-1:0] mean_us;
    logic [TimeW-1:0] percentile_us;
    logic [TimeW-1:0] max_us;
    logic [HeldW-1:0] frames_held;
    logic [CodeW-1:0] load_colour;
    logic [CodeW-1:0] verdict;
    modport source (output valid, mean_us, percentile_us, max_us, frames_held,
                    load_colour, verdict, input ready);
    modport sink   (input valid, mean_us, percentile_us, max_us, frames_held,
                    load_colour, verdict, output ready);
endinterface

// Configuration write channel
interface ftws_cfg_if;
    import ftws_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [TimeW-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ftws_ram.sv =====
module ftws_ram #(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ftws_div.sv =====
module ftws_div #(
    parameter int unsigned DW = 29,
    parameter int unsigned VW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_num;
    logic [VW:0]   r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   w_trial;
    logic          w_fits;

    // One quotient bit per cycle, restoring
    assign w_trial = {r_rem[VW-1:0], r_num[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], w_fits};
            r_rem <= w_fits ? (w_trial - {1'b0, r_div}) : w_trial;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== design/frame_time_window_statistics.sv =====
// Frame-time window statistics.
// i_in carries one item per frame: operation (push or clear), the frame time
// and the simulation cost in us. A zero-time push leaves the window as is.
// o_out returns one result item per input item: mean, percentile, max, the
// number of held frames, a load colour and a triage verdict.
// i_cfg writes the budget, percentile fraction and share limit; it is always
// ready and is meant to be used only while the block is idle.
// Each item runs through one ring RAM under a sequencer: a sum/max pass
// over n held entries, a serial divide, then rank selection that takes one
// candidate at a time and counts it against all n entries, up to n
// candidates; an empty window skips the divide and rank selection. The
// single-port RAM sets the worst-case run time.
// i_in.ready is high only while idle. A finished result sits in the output
// register; if the receiver stalls, the next item is still taken but its
// result waits at the last step until the register is free.
// Reset empties the window (fill count and write position to zero) and loads
// the register defaults; no RAM clearing pass is needed.
module frame_time_window_statistics
    import ftws_pkg::*;
#(
    parameter int unsigned WINDOW_DEPTH = 256,
    parameter int unsigned SAMPLE_BITS  = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ftws_in_if.sink    i_in,
    ftws_out_if.source o_out,
    ftws_cfg_if.sink   i_cfg
);

    localparam int unsigned AW   = $clog2(WINDOW_DEPTH);
    localparam int unsigned NW   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned SUMW = SAMPLE_BITS + NW;
    localparam int unsigned RPW  = FracW + NW;
    localparam int unsigned PRW  = FracW + TimeW;

    t_state r_state, n_state;

    // Configuration
    logic [TimeW-1:0] r_budget;
    logic [FracW-1:0] r_pct_frac;
    logic [FracW-1:0] r_share;

    // Captured item
    logic                   r_op;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [TimeW-1:0]       r_sim;

    // Window state
    logic [AW-1:0] r_pos;
    logic [NW-1:0] r_fill;

    // Work registers
    logic [NW-1:0]          r_idx;
    logic                   r_rd_vld;
    logic [SUMW-1:0]        r_sum;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [TimeW-1:0]       r_mean;
    logic [NW-1:0]          r_rank;
    logic [NW-1:0]          r_ci;
    logic [SAMPLE_BITS-1:0] r_cand;
    logic [NW-1:0]          r_lt;
    logic [NW-1:0]          r_le;
    logic [SAMPLE_BITS-1:0] r_pct;
    logic [PRW-1:0]         r_prod;

    // Output register
    logic             r_out_valid;
    logic [TimeW-1:0] r_out_mean;
    logic [TimeW-1:0] r_out_pct;
    logic [TimeW-1:0] r_out_max;
    logic [HeldW-1:0] r_out_held;
    logic [CodeW-1:0] r_out_colour;
    logic [CodeW-1:0] r_out_verdict;

    // Control decoded from state
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_addr;
    logic                   w_div_start;
    logic                   w_issue;
    logic [SAMPLE_BITS-1:0] w_rdata;
    logic                   w_div_done;
    logic [SUMW-1:0]        w_quot;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_pass_done;
    logic                   w_found;
    logic [RPW-1:0]         w_rank_raw;
    logic [NW-1:0]          w_nm1;
    logic [TimeW-1:0]       w_budget_eff;
    logic                   w_within;
    logic                   w_within15;
    logic                   w_sim_dom;
    logic [CodeW-1:0]       w_colour;
    logic [CodeW-1:0]       w_verdict;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_pass_done = (r_idx >= r_fill) && !r_rd_vld;
    assign w_found     = (r_lt <= r_rank) && (r_rank < r_le);
    assign w_nm1       = r_fill - 1'b1;
    assign w_rank_raw  = RPW'(r_pct_frac) * RPW'(w_nm1) + RPW'(Q16Half);

    // Ring memory
    ftws_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (r_sample),
        .o_rdata (w_rdata)
    );

    // Serial divider for the mean
    ftws_div #(
        .DW (SUMW),
        .VW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_accept) n_state = S_APPLY;
            S_APPLY:     n_state = S_SUM;
            S_SUM: begin
                if (w_pass_done) n_state = (r_fill == '0) ? S_PROD : S_DIV;
            end
            S_DIV:       n_state = S_WAITDIV;
            S_WAITDIV:   if (w_div_done) n_state = S_RANK;
            S_RANK:      n_state = S_CAND;
            S_CAND:      n_state = S_CAND_WAIT;
            S_CAND_WAIT: n_state = S_SCAN;
            S_SCAN:      if (w_pass_done) n_state = S_JUDGE;
            S_JUDGE:     n_state = w_found ? S_PROD : S_CAND;
            S_PROD:      n_state = S_FINISH;
            S_FINISH:    if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // State-decoded controls
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_addr  = r_idx[AW-1:0];
        w_div_start = 1'b0;
        w_issue     = 1'b0;
        unique case (r_state)
            S_APPLY: begin
                w_ram_we   = (r_op == OP_PUSH) && (r_sample != '0);
                w_ram_addr = r_pos;
            end
            S_SUM, S_SCAN: w_issue = (r_idx < r_fill);
            S_DIV:         w_div_start = 1'b1;
            S_CAND:        w_ram_addr = r_ci[AW-1:0];
            default: ;
        endcase
    end

    // Result judgement on the truncated mean
    assign w_budget_eff = (r_budget < BudgetFloorUs) ? BudgetFloorUs : r_budget;
    assign w_within     = (r_mean <= w_budget_eff);
    assign w_within15   = ((TimeW + 2)'({r_mean, 1'b0})
                           <= (TimeW + 2)'({w_budget_eff, 1'b0}) + (TimeW + 2)'(w_budget_eff));
    assign w_sim_dom    = ({1'b0, r_sim, 16'h0} > r_prod);

    always_comb begin
        priority if (w_within) w_colour = COLOUR_OK;
        else if (w_within15)   w_colour = COLOUR_WARN;
        else                   w_colour = COLOUR_OVER;
        priority if (r_fill == '0) w_verdict = VERDICT_EMPTY;
        else if (w_within)         w_verdict = VERDICT_OK;
        else if (w_sim_dom)        w_verdict = VERDICT_SIM;
        else                       w_verdict = VERDICT_OTHER;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= TimeW'(16667);
            r_pct_frac  <= FracW'(62259);
            r_share     <= FracW'(22938);
            r_pos       <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_FRAME_BUDGET: r_budget   <= i_cfg.data;
                    CFG_PCT_FRAC:     r_pct_frac <= FracW'(i_cfg.data);
                    CFG_SHARE_LIMIT:  r_share    <= FracW'(i_cfg.data);
                    default: ;
                endcase
            end

            // Window update
            if (r_state == S_APPLY) begin
                if (r_op == OP_CLEAR) begin
                    r_pos  <= '0;
                    r_fill <= '0;
                end else if (r_sample != '0) begin
                    r_pos <= (r_pos == AW'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
                    if (r_fill < NW'(WINDOW_DEPTH)) r_fill <= r_fill + 1'b1;
                end
            end

            r_rd_vld <= w_issue;

            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in.operation;
            r_sample <= SAMPLE_BITS'(i_in.frame_time_us);
            r_sim    <= i_in.sim_cost_us;
        end

        unique case (r_state)
            S_APPLY: begin
                r_idx  <= '0;
                r_sum  <= '0;
                r_max  <= '0;
                r_mean <= '0;
                r_pct  <= '0;
            end
            S_SUM: begin
                if (w_issue) r_idx <= r_idx + 1'b1;
                if (r_rd_vld) begin
                    r_sum <= r_sum + SUMW'(w_rdata);
                    if (w_rdata > r_max) r_max <= w_rdata;
                end
            end
            S_WAITDIV: if (w_div_done) r_mean <= TimeW'(w_quot);
            S_RANK: begin
                r_ci   <= '0;
                r_rank <= (w_rank_raw[RPW-1:16] > (RPW - 16)'(w_nm1))
                          ? w_nm1 : NW'(w_rank_raw[RPW-1:16]);
            end
            S_CAND_WAIT: begin
                r_cand <= w_rdata;
                r_idx  <= '0;
                r_lt   <= '0;
                r_le   <= '0;
            end
            S_SCAN: begin
                if (w_issue) r_idx <= r_idx + 1'b1;
                if (r_rd_vld) begin
                    if (w_rdata < r_cand)  r_lt <= r_lt + 1'b1;
                    if (w_rdata <= r_cand) r_le <= r_le + 1'b1;
                end
            end
            S_JUDGE: begin
                if (w_found) r_pct <= r_cand;
                else         r_ci  <= r_ci + 1'b1;
            end
            S_PROD: r_prod <= PRW'(r_share) * PRW'(r_mean);
            S_FINISH: begin
                if (w_out_free) begin
                    r_out_mean    <= r_mean;
                    r_out_pct     <= TimeW'(r_pct);
                    r_out_max     <= TimeW'(r_max);
                    r_out_held    <= HeldW'(r_fill);
                    r_out_colour  <= w_colour;
                    r_out_verdict <= w_verdict;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.mean_us       = r_out_mean;
    assign o_out.percentile_us = r_out_pct;
    assign o_out.max_us        = r_out_max;
    assign o_out.frames_held   = r_out_held;
    assign o_out.load_colour   = r_out_colour;
    assign o_out.verdict       = r_out_verdict;

endmodule

// ===== tb/ftws_tb_if.sv =====
// Channels are the block's own interfaces; this file only groups the
// testbench-side helpers that several processes share.
package ftws_tb_pkg;
    import ftws_pkg::*;

    // One result item as the block returns it
    typedef struct packed {
        logic [TimeW-1:0] mean_us;
        logic [TimeW-1:0] percentile_us;
        logic [TimeW-1:0] max_us;
        logic [HeldW-1:0] frames_held;
        logic [CodeW-1:0] load_colour;
        logic [CodeW-1:0] verdict;
    } t_stats;

    // One row of the directed table
    typedef struct packed {
        t_op              op;
        logic [TimeW-1:0] frame_time_us;
        logic [TimeW-1:0] sim_cost_us;
        logic             typed;
        t_stats           stats;
    } t_stim_row;
endpackage

// ===== tb/tb_frame_time_window_statistics.sv =====
module tb_frame_time_window_statistics;
    import ftws_pkg::*;
    import ftws_tb_pkg::*;

    localparam int Depth     = 256;
    localparam int HoldLimit = 40;
    localparam int IdleLimit = 200000;
    localparam int DirRows   = 12;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ftws_in_if  in_ch ();
    ftws_out_if out_ch ();
    ftws_cfg_if cfg_ch ();

    frame_time_window_statistics u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the window and registers
    logic [TimeW-1:0] ring_q [Depth];
    logic [7:0]       wr_pos_q;
    logic [HeldW-1:0] held_q;
    logic [TimeW-1:0] budget_q;
    logic [FracW-1:0] pct_frac_q;
    logic [FracW-1:0] share_q;

    t_stats pending_stats [$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     calm = 1'b0;

    t_stim_row dir_rows [DirRows] = '{
        // clear right after reset: empty window
        '{OP_CLEAR, 20'd5, 20'd5, 1'b1,
          '{20'd0, 20'd0, 20'd0, 9'd0, COLOUR_OK, VERDICT_EMPTY}},
        // zero sample on an empty window
        '{OP_PUSH, 20'd0, 20'hFFFFF, 1'b1,
          '{20'd0, 20'd0, 20'd0, 9'd0, COLOUR_OK, VERDICT_EMPTY}},
        // largest sample, no sim cost
        '{OP_PUSH, 20'hFFFFF, 20'd0, 1'b1,
          '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 9'd1, COLOUR_OVER, VERDICT_OTHER}},
        // zero sample keeps the window
        '{OP_PUSH, 20'd0, 20'd0, 1'b1,
          '{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 9'd1, COLOUR_OVER, VERDICT_OTHER}},
        '{OP_PUSH, 20'd1, 20'hFFFFF, 1'b0, '0},
        '{OP_PUSH, 20'd16667, 20'd3000, 1'b0, '0},
        '{OP_PUSH, 20'd20000, 20'd9000, 1'b0, '0},
        '{OP_PUSH, 20'd30000, 20'd1, 1'b0, '0},
        '{OP_CLEAR, 20'hFFFFF, 20'hFFFFF, 1'b1,
          '{20'd0, 20'd0, 20'd0, 9'd0, COLOUR_OK, VERDICT_EMPTY}},
        '{OP_PUSH, 20'd16667, 20'd0, 1'b1,
          '{20'd16667, 20'd16667, 20'd16667, 9'd1, COLOUR_OK, VERDICT_OK}},
        '{OP_PUSH, 20'd25001, 20'd100, 1'b0, '0},
        '{OP_PUSH, 20'd8, 20'd0, 1'b0, '0}
    };

    task automatic report_mismatch(input string what, input logic [TimeW-1:0] got,
                                   input logic [TimeW-1:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Apply one item to the shadow window and work out its statistics
    task automatic apply_frame_item(input t_op op, input logic [TimeW-1:0] ft,
                                    input logic [TimeW-1:0] sim, output t_stats st);
        logic [TimeW-1:0] sorted [Depth];
        logic [TimeW-1:0] v;
        logic [63:0] sum, mean, bud, rank;
        int n, j;
        if (op == OP_CLEAR) begin
            foreach (ring_q[k]) ring_q[k] = '0;
            wr_pos_q = '0;
            held_q = '0;
        end else if (ft != '0) begin
            ring_q[wr_pos_q] = ft;
            wr_pos_q = wr_pos_q + 8'd1;
            if (held_q < Depth) held_q = held_q + 1'b1;
        end
        n = held_q;
        st = '0;
        sum = 0;
        mean = 0;
        bud = (budget_q < BudgetFloorUs) ? 64'(BudgetFloorUs) : 64'(budget_q);
        for (int i = 0; i < n; i++) begin
            v = ring_q[i];
            sum += v;
            if (v > st.max_us) st.max_us = v;
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        if (n > 0) begin
            mean = sum / n;
            rank = (64'(pct_frac_q) * (n - 1) + 64'(Q16Half)) >> 16;
            if (rank > n - 1) rank = n - 1;
            st.percentile_us = sorted[rank];
        end
        st.mean_us = mean[TimeW-1:0];
        st.frames_held = held_q;
        if (mean <= bud) st.load_colour = COLOUR_OK;
        else if (2 * mean <= 3 * bud) st.load_colour = COLOUR_WARN;
        else st.load_colour = COLOUR_OVER;
        if (n == 0) st.verdict = VERDICT_EMPTY;
        else if (mean <= bud) st.verdict = VERDICT_OK;
        else if ((64'(sim) << 16) > 64'(share_q) * mean) st.verdict = VERDICT_SIM;
        else st.verdict = VERDICT_OTHER;
    endtask

    // Offer one item, sometimes after a random gap, and wait for acceptance
    task automatic send_frame(input t_op op, input logic [TimeW-1:0] ft,
                              input logic [TimeW-1:0] sim, input bit typed,
                              input t_stats typed_stats);
        t_stats st;
        if (!calm && $urandom_range(99) < 13) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.frame_time_us <= ft;
        in_ch.sim_cost_us <= sim;
        do @(posedge i_clk); while (!in_ch.ready);
        apply_frame_item(op, ft, sim, st);
        pending_stats.push_back(typed ? typed_stats : st);
    endtask

    // Register write, only with nothing in flight
    task automatic write_reg(input t_cfg_idx idx, input logic [TimeW-1:0] data);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_FRAME_BUDGET: budget_q = data;
            CFG_PCT_FRAC:     pct_frac_q = data[FracW-1:0];
            default:          share_q = data[FracW-1:0];
        endcase
    endtask

    function automatic logic [TimeW-1:0] pick_frame(input logic [TimeW-1:0] bud);
        int r;
        r = $urandom_range(99);
        if (r < 6) return '0;
        if (r < 30) return TimeW'($urandom);
        if (r < 36) return 20'hFFFFF;
        return TimeW'($urandom_range(bud / 2 + 1, bud * 2 + 1));
    endfunction

    // Result side: random stall, check, watchdog
    always @(posedge i_clk) begin
        t_stats want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(99) >= 13);
            if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready ||
                cfg_ch.valid && cfg_ch.ready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IdleLimit) begin
                $display("status: fail");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_stats.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.mean_us, '0);
                end else begin
                    want = pending_stats.pop_front();
                    if (out_ch.mean_us !== want.mean_us)
                        report_mismatch("mean_us", out_ch.mean_us, want.mean_us);
                    if (out_ch.percentile_us !== want.percentile_us)
                        report_mismatch("percentile_us", out_ch.percentile_us,
                                        want.percentile_us);
                    if (out_ch.max_us !== want.max_us)
                        report_mismatch("max_us", out_ch.max_us, want.max_us);
                    if (out_ch.frames_held !== want.frames_held)
                        report_mismatch("frames_held", 20'(out_ch.frames_held),
                                        20'(want.frames_held));
                    if (out_ch.load_colour !== want.load_colour)
                        report_mismatch("load_colour", 20'(out_ch.load_colour),
                                        20'(want.load_colour));
                    if (out_ch.verdict !== want.verdict)
                        report_mismatch("verdict", 20'(out_ch.verdict), 20'(want.verdict));
                end
            end
        end
    end

    initial begin
        logic [TimeW-1:0] budgets [5] = '{20'd0, 20'd999, 20'd1000, 20'hFFFFF, 20'd16667};
        logic [TimeW-1:0] fracs [5] = '{20'd0, 20'd65536, 20'd131071, 20'd32768, 20'd62259};
        logic [TimeW-1:0] shares [5] = '{20'd65536, 20'd0, 20'd131071, 20'd1, 20'd22938};
        logic [TimeW-1:0] ft;
        int waited;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_PUSH;
        in_ch.frame_time_us = '0;
        in_ch.sim_cost_us = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_FRAME_BUDGET;
        cfg_ch.data = '0;
        foreach (ring_q[k]) ring_q[k] = '0;
        wr_pos_q = '0;
        held_q = '0;
        budget_q = 20'd16667;
        pct_frac_q = 17'd62259;
        share_q = 17'd22938;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table on reset defaults
        foreach (dir_rows[r])
            send_frame(dir_rows[r].op, dir_rows[r].frame_time_us, dir_rows[r].sim_cost_us,
                       dir_rows[r].typed, dir_rows[r].stats);

        // Random phases, each under a new register setting
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_FRAME_BUDGET, ph < 4 ? budgets[ph] : 20'($urandom_range(1000, 60000)));
            write_reg(CFG_PCT_FRAC, fracs[ph]);
            write_reg(CFG_SHARE_LIMIT, shares[ph]);
            for (int i = 0; i < 20; i++) begin
                calm = (ph == 2);
                if (held_q >= HoldLimit || $urandom_range(99) < 4) begin
                    send_frame(OP_CLEAR, TimeW'($urandom), TimeW'($urandom), 1'b0, '0);
                end else begin
                    ft = pick_frame(budget_q < BudgetFloorUs ? BudgetFloorUs : budget_q);
                    send_frame(OP_PUSH, ft,
                               $urandom_range(1) ? TimeW'($urandom) :
                                                    TimeW'($urandom_range(0, ft / 2)),
                               1'b0, '0);
                end
            end
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain, then a short tail
        waited = 0;
        while (pending_stats.size() != 0 && waited < 4 * IdleLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_stats.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
